[design/vpts_pkg.sv]
// Shared types, constants and helpers for the vertex projection pipeline.
package vpts_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int COORD_W           = 32;
   localparam int VP_W              = 13;
   localparam int CSR_IDX_W         = 1;
   localparam int REQ_TDATA_W       = 136;
   localparam int REQ_TUSER_W       = 2;
   localparam int RSP_TDATA_W       = 64;
   localparam int RSP_TUSER_W       = 1;
   localparam int WIDE_W            = 66;

   localparam logic [VP_W-1:0] VP_WIDTH_RESET  = 13'd640;
   localparam logic [VP_W-1:0] VP_HEIGHT_RESET = 13'd480;

   localparam logic signed [WIDE_W-1:0] S32_MAX = 66'sd2147483647;
   localparam logic signed [WIDE_W-1:0] S32_MIN = -66'sd2147483648;

   typedef enum logic {
      OP_LOAD    = 1'b0,
      OP_PROJECT = 1'b1
   } op_type;

   typedef enum logic {
      MAT_VIEW = 1'b0,
      MAT_PROJ = 1'b1
   } mat_sel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VP_WIDTH  = 1'b0,
      CSR_VP_HEIGHT = 1'b1
   } csr_idx_type;

   // Status that rides along with a point through the divider and viewport stages
   typedef struct packed {
      logic valid;
      logic visible;
   } vpts_tag_type;

   // Clamp a wide signed value into the 32-bit signed range
   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > S32_MAX) begin
         r = S32_MAX[COORD_W-1:0];
      end else if (v < S32_MIN) begin
         r = S32_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

[design/vpts_xform.sv]
// Input register, matrix storage and the two pipelined matrix-vector products (4x4 view, x, y, w rows of projection).
module vpts_xform #(
   parameter int FRACTION_BITS = vpts_pkg::FRACTION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  vpts_pkg::op_type                  in_op,
   input  vpts_pkg::mat_sel_type             in_sel,
   input  logic [1:0]                        in_row,
   input  logic [1:0]                        in_col,
   input  logic signed [vpts_pkg::COORD_W-1:0] in_value,
   input  logic signed [vpts_pkg::COORD_W-1:0] in_x,
   input  logic signed [vpts_pkg::COORD_W-1:0] in_y,
   input  logic signed [vpts_pkg::COORD_W-1:0] in_z,
   output logic                              out_valid,
   output logic signed [vpts_pkg::COORD_W-1:0] out_clip_x,
   output logic signed [vpts_pkg::COORD_W-1:0] out_clip_y,
   output logic signed [vpts_pkg::COORD_W-1:0] out_clip_w
);
   import vpts_pkg::*;

   localparam int PW = 2 * COORD_W;           // full product
   localparam int TW = PW - FRACTION_BITS;    // product after floor shift
   localparam int SW = TW + 2;                // sum of four terms
   localparam int CLIP_ROW [3] = '{0, 1, 3};  // depth row is never used

   // stage 0: input register
   logic                      s0_vld_ff;
   op_type                    s0_op_ff;
   mat_sel_type               s0_sel_ff;
   logic [3:0]                s0_idx_ff;
   logic signed [COORD_W-1:0] s0_val_ff;
   logic signed [COORD_W-1:0] s0_p_ff [3];

   // matrices, row-major
   logic signed [COORD_W-1:0] vm_ff [16];
   logic signed [COORD_W-1:0] pm_ff [16];

   // stage 1: view products
   logic                      s1_vld_ff;
   op_type                    s1_op_ff;
   mat_sel_type               s1_sel_ff;
   logic [3:0]                s1_idx_ff;
   logic signed [COORD_W-1:0] s1_val_ff;
   logic signed [TW-1:0]      s1_term_ff [4][4];
   logic signed [TW-1:0]      s1_term_in [4][4];

   // stage 2: eye coordinates
   logic                      s2_vld_ff;
   op_type                    s2_op_ff;
   mat_sel_type               s2_sel_ff;
   logic [3:0]                s2_idx_ff;
   logic signed [COORD_W-1:0] s2_val_ff;
   logic signed [COORD_W-1:0] s2_eye_ff [4];
   logic signed [COORD_W-1:0] s2_eye_in [4];

   // stage 3: projection products (x, y, w rows)
   logic                      s3_vld_ff;
   logic                      s3_vld_in;
   logic signed [TW-1:0]      s3_term_ff [3][4];
   logic signed [TW-1:0]      s3_term_in [3][4];

   // stage 4: clip coordinates
   logic                      s4_vld_ff;
   logic signed [COORD_W-1:0] s4_clip_ff [3];
   logic signed [COORD_W-1:0] s4_clip_in [3];

   logic view_wr;
   logic proj_wr;

   assign view_wr   = en && s0_vld_ff && (s0_op_ff == OP_LOAD) && (s0_sel_ff == MAT_VIEW);
   assign proj_wr   = en && s2_vld_ff && (s2_op_ff == OP_LOAD) && (s2_sel_ff == MAT_PROJ);
   assign s3_vld_in = s2_vld_ff && (s2_op_ff == OP_PROJECT);

   // view matrix times (x, y, z, 1); the w column passes the element itself
   always_comb begin
      logic signed [PW-1:0] prod;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod             = vm_ff[i*4+j] * s0_p_ff[j];
            s1_term_in[i][j] = prod[PW-1:FRACTION_BITS];
         end
         s1_term_in[i][3] = {{(TW-COORD_W){vm_ff[i*4+3][COORD_W-1]}}, vm_ff[i*4+3]};
      end
   end

   // sum the view terms and clamp
   always_comb begin
      logic signed [SW-1:0] sum;
      for (int i = 0; i < 4; i++) begin
         sum = '0;
         for (int j = 0; j < 4; j++) begin
            sum = sum + {{2{s1_term_ff[i][j][TW-1]}}, s1_term_ff[i][j]};
         end
         s2_eye_in[i] = sat32({{(WIDE_W-SW){sum[SW-1]}}, sum});
      end
   end

   // projection matrix times eye vector
   always_comb begin
      logic signed [PW-1:0] prod;
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 4; j++) begin
            prod             = pm_ff[CLIP_ROW[r]*4+j] * s2_eye_ff[j];
            s3_term_in[r][j] = prod[PW-1:FRACTION_BITS];
         end
      end
   end

   // sum the projection terms and clamp
   always_comb begin
      logic signed [SW-1:0] sum;
      for (int r = 0; r < 3; r++) begin
         sum = '0;
         for (int j = 0; j < 4; j++) begin
            sum = sum + {{2{s3_term_ff[r][j][TW-1]}}, s3_term_ff[r][j]};
         end
         s4_clip_in[r] = sat32({{(WIDE_W-SW){sum[SW-1]}}, sum});
      end
   end

   // valid bits and matrices
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         for (int k = 0; k < 16; k++) begin
            vm_ff[k] <= '0;
            pm_ff[k] <= '0;
         end
      end else begin
         if (en) begin
            s0_vld_ff <= in_valid;
            s1_vld_ff <= s0_vld_ff;
            s2_vld_ff <= s1_vld_ff;
            s3_vld_ff <= s3_vld_in;
            s4_vld_ff <= s3_vld_ff;
         end
         // a load writes as it leaves the stage that reads its matrix
         if (view_wr) begin
            vm_ff[s0_idx_ff] <= s0_val_ff;
         end
         if (proj_wr) begin
            pm_ff[s2_idx_ff] <= s2_val_ff;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (en) begin
         s0_op_ff   <= in_op;
         s0_sel_ff  <= in_sel;
         s0_idx_ff  <= {in_row, in_col};
         s0_val_ff  <= in_value;
         s0_p_ff[0] <= in_x;
         s0_p_ff[1] <= in_y;
         s0_p_ff[2] <= in_z;

         s1_op_ff   <= s0_op_ff;
         s1_sel_ff  <= s0_sel_ff;
         s1_idx_ff  <= s0_idx_ff;
         s1_val_ff  <= s0_val_ff;
         s1_term_ff <= s1_term_in;

         s2_op_ff   <= s1_op_ff;
         s2_sel_ff  <= s1_sel_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_val_ff  <= s1_val_ff;
         s2_eye_ff  <= s2_eye_in;

         s3_term_ff <= s3_term_in;
         s4_clip_ff <= s4_clip_in;
      end
   end

   assign out_valid  = s4_vld_ff;
   assign out_clip_x = s4_clip_ff[0];
   assign out_clip_y = s4_clip_ff[1];
   assign out_clip_w = s4_clip_ff[2];

endmodule

[design/vpts_div.sv]
// Pipelined restoring divider, one quotient bit per stage, x and y lanes share w.
module vpts_div #(
   parameter int FRACTION_BITS = vpts_pkg::FRACTION_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          en,
   input  logic                                          in_valid,
   input  logic signed [vpts_pkg::COORD_W-1:0]           in_clip_x,
   input  logic signed [vpts_pkg::COORD_W-1:0]           in_clip_y,
   input  logic signed [vpts_pkg::COORD_W-1:0]           in_clip_w,
   output vpts_pkg::vpts_tag_type                        out_tag,
   output logic [vpts_pkg::COORD_W+FRACTION_BITS-1:0]    out_q_x,
   output logic [vpts_pkg::COORD_W+FRACTION_BITS-1:0]    out_q_y,
   output logic                                          out_neg_x,
   output logic                                          out_neg_y
);
   import vpts_pkg::*;

   localparam int DW = COORD_W + FRACTION_BITS;

   // per-stage registers
   vpts_tag_type       tag_ff [DW];
   logic [COORD_W-1:0] w_ff   [DW];
   logic [DW-1:0]      num_ff [DW][2];
   logic [COORD_W-1:0] rem_ff [DW][2];
   logic               neg_ff [DW][2];

   // stage inputs
   vpts_tag_type       tag_src [DW];
   logic [COORD_W-1:0] w_src   [DW];
   logic [DW-1:0]      num_src [DW][2];
   logic [COORD_W-1:0] rem_src [DW][2];
   logic               neg_src [DW][2];

   logic [DW-1:0]      num_in  [DW][2];
   logic [COORD_W-1:0] rem_in  [DW][2];

   logic               prep_neg [2];
   logic [COORD_W-1:0] prep_mag [2];

   // sign and magnitude of the scaled dividends
   always_comb begin
      prep_neg[0] = in_clip_x[COORD_W-1];
      prep_neg[1] = in_clip_y[COORD_W-1];
      prep_mag[0] = prep_neg[0] ? (~in_clip_x + 1'b1) : in_clip_x;
      prep_mag[1] = prep_neg[1] ? (~in_clip_y + 1'b1) : in_clip_y;
   end

   for (genvar k = 0; k < DW; k++) begin : g_stage
      if (k == 0) begin : g_first
         always_comb begin
            tag_src[0].valid   = in_valid;
            tag_src[0].visible = (in_clip_w > 0);
            w_src[0]           = in_clip_w;
            for (int l = 0; l < 2; l++) begin
               num_src[0][l] = {prep_mag[l], {FRACTION_BITS{1'b0}}};
               rem_src[0][l] = '0;
               neg_src[0][l] = prep_neg[l];
            end
         end
      end else begin : g_next
         always_comb begin
            tag_src[k] = tag_ff[k-1];
            w_src[k]   = w_ff[k-1];
            for (int l = 0; l < 2; l++) begin
               num_src[k][l] = num_ff[k-1][l];
               rem_src[k][l] = rem_ff[k-1][l];
               neg_src[k][l] = neg_ff[k-1][l];
            end
         end
      end

      // one trial subtract per lane; quotient bits shift in from the right
      always_comb begin
         logic [COORD_W:0] r2;
         logic [COORD_W:0] diff;
         for (int l = 0; l < 2; l++) begin
            r2   = {rem_src[k][l], num_src[k][l][DW-1]};
            diff = r2 - {1'b0, w_src[k]};
            if (r2 >= {1'b0, w_src[k]}) begin
               rem_in[k][l] = diff[COORD_W-1:0];
               num_in[k][l] = {num_src[k][l][DW-2:0], 1'b1};
            end else begin
               rem_in[k][l] = r2[COORD_W-1:0];
               num_in[k][l] = {num_src[k][l][DW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[k] <= '0;
         end else if (en) begin
            tag_ff[k] <= tag_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            w_ff[k] <= w_src[k];
            for (int l = 0; l < 2; l++) begin
               num_ff[k][l] <= num_in[k][l];
               rem_ff[k][l] <= rem_in[k][l];
               neg_ff[k][l] <= neg_src[k][l];
            end
         end
      end
   end

   assign out_tag   = tag_ff[DW-1];
   assign out_q_x   = num_ff[DW-1][0];
   assign out_q_y   = num_ff[DW-1][1];
   assign out_neg_x = neg_ff[DW-1][0];
   assign out_neg_y = neg_ff[DW-1][1];

endmodule

[design/vpts_vport.sv]
// Quotient signing and clamping, then the viewport scale to pixel coordinates.
module vpts_vport #(
   parameter int FRACTION_BITS = vpts_pkg::FRACTION_BITS_DEF
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       en,
   input  vpts_pkg::vpts_tag_type                     in_tag,
   input  logic [vpts_pkg::COORD_W+FRACTION_BITS-1:0] in_q_x,
   input  logic [vpts_pkg::COORD_W+FRACTION_BITS-1:0] in_q_y,
   input  logic                                       in_neg_x,
   input  logic                                       in_neg_y,
   input  logic [vpts_pkg::VP_W-1:0]                  vp_width,
   input  logic [vpts_pkg::VP_W-1:0]                  vp_height,
   output vpts_pkg::vpts_tag_type                     out_tag,
   output logic signed [vpts_pkg::COORD_W-1:0]        out_screen_x,
   output logic signed [vpts_pkg::COORD_W-1:0]        out_screen_y
);
   import vpts_pkg::*;

   localparam int DW = COORD_W + FRACTION_BITS;
   localparam int AW = COORD_W + 1;          // ndc plus or minus one
   localparam int MW = AW + VP_W + 1;        // scaled by the viewport size
   localparam logic signed [AW-1:0] ONE = 33'sd1 <<< FRACTION_BITS;

   vpts_tag_type              a_tag_ff, b_tag_ff, c_tag_ff;
   logic signed [AW-1:0]      a_x_ff, a_y_ff, a_x_in, a_y_in;
   logic signed [MW-1:0]      b_x_ff, b_y_ff, b_x_in, b_y_in;
   logic signed [COORD_W-1:0] c_x_ff, c_y_ff, c_x_in, c_y_in;

   // stage A: signed, clamped ndc, offset for the viewport mapping
   always_comb begin
      logic signed [WIDE_W-1:0] vx;
      logic signed [WIDE_W-1:0] vy;
      logic signed [COORD_W-1:0] nx;
      logic signed [COORD_W-1:0] ny;
      vx = {{(WIDE_W-DW){1'b0}}, in_q_x};
      vy = {{(WIDE_W-DW){1'b0}}, in_q_y};
      nx = sat32(in_neg_x ? -vx : vx);
      ny = sat32(in_neg_y ? -vy : vy);
      a_x_in = {nx[COORD_W-1], nx} + ONE;
      a_y_in = ONE - {ny[COORD_W-1], ny};
   end

   // stage B: scale by viewport size
   always_comb begin
      b_x_in = a_x_ff * $signed({1'b0, vp_width});
      b_y_in = a_y_ff * $signed({1'b0, vp_height});
   end

   // stage C: halve with floor, clamp, blank points that are not visible
   always_comb begin
      c_x_in = sat32({{(WIDE_W-MW+1){b_x_ff[MW-1]}}, b_x_ff[MW-1:1]});
      c_y_in = sat32({{(WIDE_W-MW+1){b_y_ff[MW-1]}}, b_y_ff[MW-1:1]});
      if (!b_tag_ff.visible) begin
         c_x_in = '0;
         c_y_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_tag_ff <= '0;
         b_tag_ff <= '0;
         c_tag_ff <= '0;
      end else if (en) begin
         a_tag_ff <= in_tag;
         b_tag_ff <= a_tag_ff;
         c_tag_ff <= b_tag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_x_ff <= a_x_in;
         a_y_ff <= a_y_in;
         b_x_ff <= b_x_in;
         b_y_ff <= b_y_in;
         c_x_ff <= c_x_in;
         c_y_ff <= c_y_in;
      end
   end

   assign out_tag      = c_tag_ff;
   assign out_screen_x = c_x_ff;
   assign out_screen_y = c_y_ff;

endmodule

[design/vertex_project_to_screen.sv]
// Top level of the vertex projection pipeline: ports, settings, output register and skid.
//
// Usage:
//   req_* carries one item per transfer. A load item (req_tuser[0] = 0) writes one
//   element of the view or projection matrix and yields no result. A project item
//   (req_tuser[0] = 1) yields one rsp_* transfer with the visible flag and the screen
//   position in signed fixed point; a point behind the eye returns zeros.
//   csr_* writes the viewport width (index 0) or height (index 1); csr_ready is
//   always high. Write it only while no item is in flight.
// Timing:
//   Throughput is one item per cycle while the skid register is empty. An item passes
//   from the req transfer to rsp_tvalid through the input register, the matrix
//   products, the divider, which resolves one quotient bit per stage, the viewport
//   scaling and the output register.
// Reset:
//   Both matrices clear to zero, the viewport returns to 640 x 480 and the
//   pipeline empties.
// Back-pressure:
//   When rsp_tready is low the result holds on rsp_*, one further result parks in
//   a skid register, and then the whole pipeline and req_tready hold until the
//   receiver drains it. Nothing is lost or repeated.
module vertex_project_to_screen #(
   parameter int FRACTION_BITS = vpts_pkg::FRACTION_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: row_index[1:0], column_index[3:2], element_value[35:4],
   //            point_x[67:36], point_y[99:68], point_z[131:100], zero pad
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [vpts_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // req_tuser: operation[0], matrix_select[1]
   input  logic [vpts_pkg::REQ_TUSER_W-1:0]     req_tuser,
   // rsp_tdata: screen_x[31:0], screen_y[63:32]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [vpts_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   // rsp_tuser: visible[0]
   output logic [vpts_pkg::RSP_TUSER_W-1:0]     rsp_tuser,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [vpts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vpts_pkg::VP_W-1:0]            csr_data
);
   import vpts_pkg::*;

   localparam int DW = COORD_W + FRACTION_BITS;

   logic en;

   logic [VP_W-1:0] vp_width_ff, vp_height_ff;

   logic                      xf_valid;
   logic signed [COORD_W-1:0] clip_x, clip_y, clip_w;

   vpts_tag_type  div_tag;
   logic [DW-1:0] div_q_x, div_q_y;
   logic          div_neg_x, div_neg_y;

   vpts_tag_type              vp_tag;
   logic signed [COORD_W-1:0] vp_x, vp_y;

   logic                      out_valid_ff, skid_valid_ff;
   logic                      out_vis_ff, skid_vis_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic                      out_free;

   // the pipeline moves as one while the skid register is empty
   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vp_width_ff  <= VP_WIDTH_RESET;
         vp_height_ff <= VP_HEIGHT_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_VP_WIDTH:  vp_width_ff  <= csr_data;
            CSR_VP_HEIGHT: vp_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   vpts_xform #(.FRACTION_BITS(FRACTION_BITS)) u_xform (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_tvalid),
      .in_op      (op_type'(req_tuser[0])),
      .in_sel     (mat_sel_type'(req_tuser[1])),
      .in_row     (req_tdata[1:0]),
      .in_col     (req_tdata[3:2]),
      .in_value   (req_tdata[35:4]),
      .in_x       (req_tdata[67:36]),
      .in_y       (req_tdata[99:68]),
      .in_z       (req_tdata[131:100]),
      .out_valid  (xf_valid),
      .out_clip_x (clip_x),
      .out_clip_y (clip_y),
      .out_clip_w (clip_w)
   );

   vpts_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xf_valid),
      .in_clip_x (clip_x),
      .in_clip_y (clip_y),
      .in_clip_w (clip_w),
      .out_tag   (div_tag),
      .out_q_x   (div_q_x),
      .out_q_y   (div_q_y),
      .out_neg_x (div_neg_x),
      .out_neg_y (div_neg_y)
   );

   vpts_vport #(.FRACTION_BITS(FRACTION_BITS)) u_vport (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_tag       (div_tag),
      .in_q_x       (div_q_x),
      .in_q_y       (div_q_y),
      .in_neg_x     (div_neg_x),
      .in_neg_y     (div_neg_y),
      .vp_width     (vp_width_ff),
      .vp_height    (vp_height_ff),
      .out_tag      (vp_tag),
      .out_screen_x (vp_x),
      .out_screen_y (vp_y)
   );

   // output register and skid: control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= vp_tag.valid;
         end
      end else if (!skid_valid_ff && vp_tag.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   // output register and skid: payload
   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_vis_ff <= skid_vis_ff;
            out_x_ff   <= skid_x_ff;
            out_y_ff   <= skid_y_ff;
         end else begin
            out_vis_ff <= vp_tag.visible;
            out_x_ff   <= vp_x;
            out_y_ff   <= vp_y;
         end
      end else if (!skid_valid_ff) begin
         skid_vis_ff <= vp_tag.visible;
         skid_x_ff   <= vp_x;
         skid_y_ff   <= vp_y;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = {out_y_ff, out_x_ff};
   assign rsp_tuser[0] = out_vis_ff;

   // a parked result always has one in front of it
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output register is empty");

   // a parked result moves up when the front one is taken
   a_skid_moves_up: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_tready) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid result not forwarded after a transfer");

   // a point that is not visible reports the origin
   a_hidden_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == '0))
      else $error("hidden point with nonzero screen position");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the vertex projection pipeline.
`timescale 1ns / 100ps

module tb;
   import vpts_pkg::*;

   localparam int FB = FRACTION_BITS_DEF;
   localparam int LATENCY = 40 + FB;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic signed [63:0] ONE = 64'sd1 << FB;
   localparam logic signed [31:0] ONE32 = 32'sd1 <<< FB;

   typedef struct packed {
      op_type                    op;
      mat_sel_type               msel;
      logic [1:0]                row;
      logic [1:0]                col;
      logic signed [COORD_W-1:0] elem;
      logic signed [COORD_W-1:0] px;
      logic signed [COORD_W-1:0] py;
      logic signed [COORD_W-1:0] pz;
   } vertex_item_type;

   typedef struct packed {
      logic                      visible;
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
   } screen_point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VP_W-1:0] csr_data = '0;

   vertex_project_to_screen u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [31:0] view_m[16];
   logic signed [31:0] proj_m[16];
   logic [VP_W-1:0] vp_w, vp_h;

   vertex_item_type  pending_items[$];
   screen_point_type expected_points[$];

   int  errors = 0;
   int  n_points = 0, n_visible = 0, n_loads = 0;
   int  send_idle_pct = 0, recv_stall_pct = 0;
   bit  hold_off = 1'b0;
   bit  req_taken = 1'b0;
   longint cycles = 0;

   function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // the matrix times a column vector, floor-shifted terms
   function automatic void mat_mul(input logic signed [31:0] m[16],
                                   input logic signed [63:0] p[4],
                                   output logic signed [63:0] r[4]);
      logic signed [63:0] acc;
      for (int i = 0; i < 4; i++) begin
         acc = 0;
         for (int j = 0; j < 4; j++) acc += (64'(m[i*4+j]) * p[j]) >>> FB;
         r[i] = clamp32(acc);
      end
   endfunction

   function automatic void project_point(input vertex_item_type it,
                                         output screen_point_type res);
      logic signed [63:0] p[4], eye[4], clip[4];
      logic signed [63:0] nx, ny, sx, sy;
      p[0] = 64'(it.px); p[1] = 64'(it.py); p[2] = 64'(it.pz); p[3] = ONE;
      mat_mul(view_m, p, eye);
      mat_mul(proj_m, eye, clip);
      res = '0;
      if (clip[3] > 0) begin
         nx = clamp32((clip[0] * ONE) / clip[3]);
         ny = clamp32((clip[1] * ONE) / clip[3]);
         sx = clamp32(((nx + ONE) * $signed(64'(vp_w))) >>> 1);
         sy = clamp32(((ONE - ny) * $signed(64'(vp_h))) >>> 1);
         res.visible = 1'b1;
         res.sx = sx[31:0];
         res.sy = sy[31:0];
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("tb: mismatch %s got %h want %h", what, got, want);
      errors++;
   endtask

   // driver: offers the oldest pending item, updates the predictor on transfer
   always @(negedge clock) begin
      screen_point_type r;
      if (!reset) begin
         if (req_taken) begin
            if (pending_items[0].op == OP_LOAD) begin
               if (pending_items[0].msel == MAT_PROJ)
                  proj_m[{pending_items[0].row, pending_items[0].col}] = pending_items[0].elem;
               else
                  view_m[{pending_items[0].row, pending_items[0].col}] = pending_items[0].elem;
               n_loads++;
            end else begin
               project_point(pending_items[0], r);
               expected_points.push_back(r);
               n_points++;
               if (r.visible) n_visible++;
            end
            void'(pending_items.pop_front());
         end
         if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tuser  <= {pending_items[0].msel, pending_items[0].op};
            req_tdata  <= {4'b0, pending_items[0].pz, pending_items[0].py,
                           pending_items[0].px, pending_items[0].elem,
                           pending_items[0].col, pending_items[0].row};
         end else begin
            req_tvalid <= 1'b0;
         end
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: note input transfers, compare each result with the oldest expectation
   always @(posedge clock) begin
      screen_point_type e;
      cycles <= cycles + 1;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata, 0);
         end else begin
            e = expected_points.pop_front();
            if (rsp_tuser[0] !== e.visible) report_mismatch("visible", rsp_tuser, e.visible);
            if (rsp_tdata[31:0] !== e.sx) report_mismatch("screen_x", rsp_tdata[31:0], e.sx);
            if (rsp_tdata[63:32] !== e.sy) report_mismatch("screen_y", rsp_tdata[63:32], e.sy);
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 'h80000)) - 32'sh40000;
         2: return $signed($urandom_range(0, 'h1000000)) - 32'sh800000;
         default: return $signed($urandom_range(0, 'h4000)) - 32'sh2000;
      endcase
   endfunction

   function automatic vertex_item_type load_item(mat_sel_type ms, int r, int c,
                                                 logic signed [31:0] v);
      vertex_item_type it;
      it = '0;
      it.op = OP_LOAD; it.msel = ms; it.row = 2'(r); it.col = 2'(c); it.elem = v;
      it.px = $urandom; it.py = $urandom; it.pz = $urandom;
      return it;
   endfunction

   function automatic vertex_item_type point_item(logic signed [31:0] x,
                                                  logic signed [31:0] y,
                                                  logic signed [31:0] z);
      vertex_item_type it;
      it.op = OP_PROJECT; it.msel = mat_sel_type'($urandom_range(1));
      it.row = 2'($urandom); it.col = 2'($urandom); it.elem = $urandom;
      it.px = x; it.py = y; it.pz = z;
      return it;
   endfunction

   // queue a full matrix: mostly near-identity or perspective, sometimes random
   task automatic queue_matrix(mat_sel_type ms);
      logic signed [31:0] v;
      int kind;
      kind = $urandom_range(9);
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            if (kind == 0) v = $urandom;
            else if (r == c) v = ONE32 + $signed($urandom_range(0, 'h8000)) - 32'sh4000;
            else if (ms == MAT_PROJ && r == 3 && c == 2) v = -ONE32;
            else v = $signed($urandom_range(0, 'h4000)) - 32'sh2000;
            if (ms == MAT_PROJ && r == 3 && c == 3 && kind != 0)
               v = $urandom_range(1) ? 32'sd0 : ONE32;
            pending_items.push_back(load_item(ms, r, c, v));
         end
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || expected_points.size() > 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [VP_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_VP_WIDTH) vp_w = val; else vp_h = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [VP_W-1:0] vw[5], vh[5];
      vw = '{13'd640, 13'd1, 13'd4096, 13'd8191, 13'd1920};
      vh = '{13'd480, 13'd4096, 13'd1, 13'd0, 13'd1080};
      for (int i = 0; i < 16; i++) begin view_m[i] = 0; proj_m[i] = 0; end
      vp_w = VP_WIDTH_RESET; vp_h = VP_HEIGHT_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed: zero matrices give not visible, then identity and extremes
      pending_items.push_back(point_item(32'sh7fffffff, 32'sh80000000, 0));
      for (int i = 0; i < 4; i++) begin
         pending_items.push_back(load_item(MAT_VIEW, i, i, ONE32));
         pending_items.push_back(load_item(MAT_PROJ, i, i, ONE32));
      end
      pending_items.push_back(point_item(0, 0, 0));
      pending_items.push_back(point_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      pending_items.push_back(point_item(32'sh80000000, 32'sh80000000, 32'sh80000000));
      pending_items.push_back(point_item(32'sh8000, -32'sh8000, 0));
      pending_items.push_back(load_item(MAT_PROJ, 3, 3, 32'sh80000000));
      pending_items.push_back(point_item(ONE32, ONE32, ONE32));
      pending_items.push_back(load_item(MAT_PROJ, 3, 3, 1));
      pending_items.push_back(point_item(ONE32, -ONE32, 0));
      pending_items.push_back(load_item(MAT_VIEW, 0, 0, 32'sh7fffffff));
      pending_items.push_back(point_item(32'sh7fffffff, 2, 3));
      pending_items.push_back(load_item(MAT_PROJ, 3, 3, ONE32));
      pending_items.push_back(load_item(MAT_VIEW, 0, 0, ONE32));
      drain();

      // random phases: viewport setting and idling pattern per phase
      for (int ph = 0; ph < 10; ph++) begin
         write_csr(CSR_VP_WIDTH, (ph < 5) ? vw[ph] : VP_W'($urandom_range(1, 4096)));
         write_csr(CSR_VP_HEIGHT, (ph < 5) ? vh[ph] : VP_W'($urandom_range(1, 4096)));
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         for (int n = 0; n < 57; n++) begin
            if ($urandom_range(19) == 0) queue_matrix(mat_sel_type'($urandom_range(1)));
            else if ($urandom_range(19) == 0)
               pending_items.push_back(load_item(mat_sel_type'($urandom_range(1)),
                                                 $urandom_range(3), $urandom_range(3),
                                                 $urandom));
            else pending_items.push_back(point_item(rand_coord(), rand_coord(), rand_coord()));
         end
         // long receiver hold-off so the pipeline fills and stalls its input
         if (ph == 4) begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end

      $display("tb: %0d points projected (%0d visible), %0d matrix loads", n_points,
               n_visible, n_loads);
      $display("tb: viewport extremes and four idling patterns with a long stall");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

[files.f]
design/vpts_pkg.sv
design/vpts_xform.sv
design/vpts_div.sv
design/vpts_vport.sv
design/vertex_project_to_screen.sv
tb/sv/tb.sv
